/* hw/rtl/bmpc_pkg.sv */
package bmpc_pkg;

	localparam int CHANNELS     = 8;
	localparam int WINDOW_DEPTH = 16;
	localparam int SAMPLE_BITS  = 32;

	// Fixed widths of the channel payload.
	localparam int FIELD_CH = 8;
	localparam int FIELD_W  = 32;
	localparam int BCNT_W   = 5;

	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

	localparam logic [BCNT_W-1:0] BCNT_MAX = '1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// Control that the sequencer broadcasts to every lane.
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic [CNT_W-1:0] count;
	} lane_ctrl_t;

	// Control from the sequencer to the merging stage.
	typedef struct packed {
		logic             load;
		logic [CNT_W-1:0] count;
		logic             ovf;
	} merge_ctrl_t;

endpackage

/* hw/rtl/bmpc_if.sv */
interface bmpc_in_if;
	import bmpc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] sample_0;
	logic signed [FIELD_W-1:0] sample_1;
	logic signed [FIELD_W-1:0] sample_2;
	logic signed [FIELD_W-1:0] sample_3;
	logic signed [FIELD_W-1:0] sample_4;
	logic signed [FIELD_W-1:0] sample_5;
	logic signed [FIELD_W-1:0] sample_6;
	logic signed [FIELD_W-1:0] sample_7;
	logic                      last;

	modport source (
		output valid, sample_0, sample_1, sample_2, sample_3,
		output sample_4, sample_5, sample_6, sample_7, last,
		input  ready
	);

	modport sink (
		input  valid, sample_0, sample_1, sample_2, sample_3,
		input  sample_4, sample_5, sample_6, sample_7, last,
		output ready
	);
endinterface

interface bmpc_out_if;
	import bmpc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] median_0;
	logic signed [FIELD_W-1:0] median_1;
	logic signed [FIELD_W-1:0] median_2;
	logic signed [FIELD_W-1:0] median_3;
	logic signed [FIELD_W-1:0] median_4;
	logic signed [FIELD_W-1:0] median_5;
	logic signed [FIELD_W-1:0] median_6;
	logic signed [FIELD_W-1:0] median_7;
	logic [BCNT_W-1:0]         batch_count;
	logic                      overflowed;

	modport source (
		output valid, median_0, median_1, median_2, median_3,
		output median_4, median_5, median_6, median_7, batch_count, overflowed,
		input  ready
	);

	modport sink (
		input  valid, median_0, median_1, median_2, median_3,
		input  median_4, median_5, median_6, median_7, batch_count, overflowed,
		output ready
	);
endinterface

/* hw/rtl/batch_median_per_channel_unit.sv */
// Per-channel batch median selector.
// The samples channel carries one signed sample per sensor channel and a last
// mark; an item is taken when valid and ready are both high. Items are stored
// one row per item, up to the window depth; later items of the same batch are
// dropped and reported through overflowed.
// The item marked last closes the batch. Every channel lane then walks its
// stored rows one candidate per cycle, ranks each against the whole batch and
// keeps the one at index count/2 (the upper median for an even count).
// The medians channel delivers one item per batch with all channel medians,
// the batch count and the overflow flag.
// A batch passes through loading, the selection sweep over its stored rows and
// a drain of the lane pipeline before its result is registered for output.
// Samples are refused during selection. A result waits in the output register
// while the receiver stalls; loading of the next batch goes on meanwhile, and
// only the hand-off of the following result waits for the register to free.
// Reset empties the batch and the output register; stored rows need no clearing.
module batch_median_per_channel_unit (
	input  logic       clk,
	input  logic       arst_n,
	bmpc_in_if.sink    samples,
	bmpc_out_if.source medians
);
	import bmpc_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_SWEEP = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] sweep_q;
	logic             ovf_q;
	logic             drain_q;
	logic             in_acc;
	logic             has_room;
	logic             can_load;
	lane_ctrl_t       lctl;
	merge_ctrl_t      mctl;
	sample_t          row [FIELD_CH];
	sample_t          lane_med [CHANNELS];

	assign samples.ready = (state_q == ST_LOAD);
	assign in_acc        = samples.valid && samples.ready;
	assign has_room      = fill_q < CNT_W'(WINDOW_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q  <= '0;
			sweep_q <= '0;
			ovf_q   <= 1'b0;
			drain_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (has_room) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (samples.last) begin
							state_q <= ST_SWEEP;
							sweep_q <= '0;
						end
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == CNT_W'(fill_q - 1'b1)) begin
						state_q <= ST_DRAIN;
						drain_q <= 1'b0;
					end
				end
				ST_DRAIN: begin
					// The drain state lets the last candidate pass through the lane pipeline.
					if (drain_q) begin
						state_q <= ST_EMIT;
					end else begin
						drain_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (can_load) begin
						fill_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign lctl.wr_en  = in_acc && has_room;
	assign lctl.wr_idx = fill_q[IDX_W-1:0];
	assign lctl.rd_en  = (state_q == ST_SWEEP);
	assign lctl.rd_idx = sweep_q[IDX_W-1:0];
	assign lctl.count  = fill_q;

	assign mctl.load  = (state_q == ST_EMIT);
	assign mctl.count = fill_q;
	assign mctl.ovf   = ovf_q;

	assign row[0] = sample_t'(samples.sample_0);
	assign row[1] = sample_t'(samples.sample_1);
	assign row[2] = sample_t'(samples.sample_2);
	assign row[3] = sample_t'(samples.sample_3);
	assign row[4] = sample_t'(samples.sample_4);
	assign row[5] = sample_t'(samples.sample_5);
	assign row[6] = sample_t'(samples.sample_6);
	assign row[7] = sample_t'(samples.sample_7);

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
		bmpc_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (lctl),
			.wr_data (row[ch]),
			.med     (lane_med[ch])
		);
	end

	bmpc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.mctl     (mctl),
		.lane_med (lane_med),
		.can_load (can_load),
		.medians  (medians)
	);
endmodule

/* hw/rtl/bmpc_lane.sv */
module bmpc_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmpc_pkg::lane_ctrl_t ctl,
	input  bmpc_pkg::sample_t    wr_data,
	output bmpc_pkg::sample_t    med
);
	import bmpc_pkg::*;

	sample_t                 store_q [WINDOW_DEPTH];
	sample_t                 cand_s1;
	sample_t                 cand_s2;
	logic                    v_s1;
	logic                    v_s2;
	logic [WINDOW_DEPTH-1:0] lt;
	logic [WINDOW_DEPTH-1:0] le;
	logic [WINDOW_DEPTH-1:0] lt_s2;
	logic [WINDOW_DEPTH-1:0] le_s2;
	logic [CNT_W-1:0]        n_lt;
	logic [CNT_W-1:0]        n_le;
	logic [CNT_W-1:0]        rank;
	logic                    hit;
	sample_t                 med_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			store_q[ctl.wr_idx] <= wr_data;
		end
		cand_s1 <= store_q[ctl.rd_idx];
	end

	// Each candidate is compared against every stored row of the batch at once.
	always_comb begin
		for (int j = 0; j < WINDOW_DEPTH; j++) begin
			lt[j] = (CNT_W'(j) < ctl.count) && (store_q[j] < cand_s1);
			le[j] = (CNT_W'(j) < ctl.count) && (store_q[j] <= cand_s1);
		end
	end

	always_ff @(posedge clk) begin
		cand_s2 <= cand_s1;
		lt_s2   <= lt;
		le_s2   <= le;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.rd_en;
			v_s2 <= v_s1;
		end
	end

	// The candidate sits at the wanted rank when fewer than rank+1 rows are
	// below it and more than rank rows are at or below it.
	assign n_lt = CNT_W'($countones(lt_s2));
	assign n_le = CNT_W'($countones(le_s2));
	assign rank = ctl.count >> 1;
	assign hit  = v_s2 && (n_lt <= rank) && (rank < n_le);

	always_ff @(posedge clk) begin
		if (hit) begin
			med_q <= cand_s2;
		end
	end

	assign med = med_q;
endmodule

/* hw/rtl/bmpc_merge.sv */
module bmpc_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bmpc_pkg::merge_ctrl_t mctl,
	input  bmpc_pkg::sample_t     lane_med [bmpc_pkg::CHANNELS],
	output logic                  can_load,
	bmpc_out_if.source            medians
);
	import bmpc_pkg::*;

	localparam int CMP_W = (CNT_W > BCNT_W) ? CNT_W : BCNT_W;

	logic [FIELD_W-1:0] med_vec [FIELD_CH];
	logic [FIELD_W-1:0] med_q   [FIELD_CH];
	logic [BCNT_W-1:0]  bcnt;
	logic [BCNT_W-1:0]  bcnt_q;
	logic               ovf_q;
	logic               valid_q;

	for (genvar ch = 0; ch < FIELD_CH; ch++) begin : g_ch
		if (ch < CHANNELS) begin : g_used
			assign med_vec[ch] = FIELD_W'(lane_med[ch]);
		end else begin : g_unused
			assign med_vec[ch] = '0;
		end
	end

	assign bcnt = (CMP_W'(mctl.count) > CMP_W'(BCNT_MAX)) ? BCNT_MAX : BCNT_W'(mctl.count);

	assign can_load = !valid_q || medians.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (mctl.load && can_load) begin
			valid_q <= 1'b1;
		end else if (medians.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mctl.load && can_load) begin
			med_q  <= med_vec;
			bcnt_q <= bcnt;
			ovf_q  <= mctl.ovf;
		end
	end

	assign medians.valid       = valid_q;
	assign medians.median_0    = med_q[0];
	assign medians.median_1    = med_q[1];
	assign medians.median_2    = med_q[2];
	assign medians.median_3    = med_q[3];
	assign medians.median_4    = med_q[4];
	assign medians.median_5    = med_q[5];
	assign medians.median_6    = med_q[6];
	assign medians.median_7    = med_q[7];
	assign medians.batch_count = bcnt_q;
	assign medians.overflowed  = ovf_q;
endmodule

/* hw/rtl/bmpc_port_chk.sv */
module bmpc_port_chk (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic                                    in_last,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [bmpc_pkg::FIELD_W-1:0]     median_0,
	input logic signed [bmpc_pkg::FIELD_W-1:0]     median_7,
	input logic [bmpc_pkg::BCNT_W-1:0]             batch_count,
	input logic                                    overflowed
);
	import bmpc_pkg::*;

	localparam int FULL_CNT = (WINDOW_DEPTH > 31) ? 31 : WINDOW_DEPTH;

	// A stalled result holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(median_0) && $stable(median_7)
			&& $stable(batch_count) && $stable(overflowed))
		else $error("result changed while stalled");

	// Every batch holds at least one row.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> batch_count != '0)
		else $error("batch count of zero");

	// A batch that overflowed filled the whole window.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflowed |-> batch_count == BCNT_W'(FULL_CNT))
		else $error("overflow reported on a window that was not full");

	// Closing a batch stops intake while the selection runs.
	a_close_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("item taken right after a batch closed");

	// A new result only appears once intake has been held off.
	a_emit_gap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while samples were being taken");
endmodule

bind batch_median_per_channel_unit bmpc_port_chk u_port_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.in_last     (samples.last),
	.out_valid   (medians.valid),
	.out_ready   (medians.ready),
	.median_0    (medians.median_0),
	.median_7    (medians.median_7),
	.batch_count (medians.batch_count),
	.overflowed  (medians.overflowed)
);
